FILE: hdl/smpm_pkg.sv
// Shared types and constants for the striped mirror placement mapper.
package smpm_pkg;

	localparam int MAX_NODES    = 4;
	localparam int MAX_SEGMENTS = 64;
	localparam int NODE_W       = $clog2(MAX_NODES);
	localparam int NCNT_W       = $clog2(MAX_NODES + 1);
	localparam int OFF_W        = 50;
	localparam int LEN_W        = 32;
	localparam int CAP_W        = 48;
	localparam int STAT_W       = 3;
	localparam int IDX_W        = 3;
	localparam int DIV_STEPS    = OFF_W;
	localparam int DCNT_W       = $clog2(DIV_STEPS + 1);
	localparam int MCNT_W       = $clog2(LEN_W);

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_OFFSET    = 3'd1;
	localparam logic [STAT_W-1:0] ST_RANGE     = 3'd2;
	localparam logic [STAT_W-1:0] ST_NODE_CAP  = 3'd3;
	localparam logic [STAT_W-1:0] ST_TOO_MANY  = 3'd4;

	localparam logic [IDX_W-1:0] REG_STRIPE = 3'd0;
	localparam logic [IDX_W-1:0] REG_NODES  = 3'd1;
	localparam logic [IDX_W-1:0] REG_CAP0   = 3'd2;
	localparam logic [IDX_W-1:0] REG_CAP1   = 3'd3;
	localparam logic [IDX_W-1:0] REG_CAP2   = 3'd4;
	localparam logic [IDX_W-1:0] REG_CAP3   = 3'd5;
	localparam logic [IDX_W-1:0] REG_ACTIVE = 3'd6;

	typedef struct packed {
		logic [OFF_W-1:0] start_offset;
		logic [LEN_W-1:0] request_length;
	} req_t;

	typedef struct packed {
		logic [OFF_W-1:0]  seg_offset;
		logic [LEN_W-1:0]  seg_length;
		logic [1:0]        primary_node;
		logic [CAP_W-1:0]  primary_offset;
		logic              primary_up;
		logic              mirror_present;
		logic [1:0]        mirror_node;
		logic [CAP_W-1:0]  mirror_offset;
		logic              mirror_up;
		logic [STAT_W-1:0] status;
		logic              last_segment;
	} seg_t;

	// effective configuration seen by the front and back
	typedef struct packed {
		logic [LEN_W-1:0]                 stripe;
		logic [NCNT_W-1:0]                nodes;
		logic [MAX_NODES-1:0]             active;
		logic [MAX_NODES-1:0][CAP_W-1:0]  cap;
	} cfg_t;

	typedef struct packed {
		logic                             single;
		logic [STAT_W-1:0]                status;
		logic [OFF_W-1:0]                 off;
		logic [LEN_W-1:0]                 len;
		logic [LEN_W-1:0]                 in_stripe;
		logic [NODE_W-1:0]                p0;
		logic [CAP_W-1:0]                 base;
		logic [MAX_NODES-1:0][CAP_W-1:0]  usable;
	} cmd_t;

	typedef enum logic [2:0] {
		F_IDLE, F_DIV1, F_CHECK, F_DIV2, F_MUL, F_PUSH
	} fstate_t;

endpackage

FILE: hdl/smpm_div.sv
// Restoring divider lane: one quotient bit per cycle.
module smpm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [smpm_pkg::OFF_W-1:0]   dividend,
	input  logic [smpm_pkg::LEN_W-1:0]   divisor,
	output logic                         busy,
	output logic [smpm_pkg::OFF_W-1:0]   quotient,
	output logic [smpm_pkg::LEN_W-1:0]   remainder
);
	import smpm_pkg::*;

	logic [DCNT_W-1:0] cnt_q;
	logic [LEN_W-1:0]  rem_q;
	logic [OFF_W-1:0]  quo_q;
	logic [LEN_W-1:0]  d_q;
	logic [LEN_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, quo_q[OFF_W-1]};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DCNT_W'(DIV_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			d_q   <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? LEN_W'(trial - {1'b0, d_q}) : LEN_W'(trial);
			quo_q <= {quo_q[OFF_W-2:0], ge};
		end
	end

	assign busy      = cnt_q != '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

FILE: hdl/smpm_front.sv
// Front end: accepts requests, checks capacity and computes the start of the walk.
module smpm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  smpm_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  smpm_pkg::req_t      in_data,
	output logic                push,
	input  logic                full,
	output smpm_pkg::cmd_t      cmd
);
	import smpm_pkg::*;

	localparam int LANES = 2 + MAX_NODES;

	fstate_t state_q, state_d;
	logic [LANES-1:0]              start;
	logic [LANES-1:0]              busy;
	logic [LANES-1:0][OFF_W-1:0]   dvd;
	logic [LANES-1:0][LEN_W-1:0]   dvs;
	logic [LANES-1:0][OFF_W-1:0]   quo;
	logic [LANES-1:0][LEN_W-1:0]   rem;

	req_t                          req_q;
	cmd_t                          cmd_q;
	logic [CAP_W-1:0]              row_q;
	logic [MCNT_W-1:0]             mcnt_q;
	logic [MAX_NODES-1:0][CAP_W-1:0] usable;
	logic [CAP_W-1:0]              min_cap;
	logic [OFF_W-1:0]              exposed;
	logic [OFF_W-1:0]              span;
	logic                          single;
	logic [STAT_W-1:0]             status;
	logic [OFF_W-1:0]              end_off;

	assign end_off = OFF_W'(in_data.start_offset + OFF_W'(in_data.request_length) - OFF_W'(1));

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			dvs[i] = cfg.stripe;
			dvd[i] = '0;
		end
		dvd[0] = in_data.start_offset;
		dvd[1] = end_off;
		for (int i = 0; i < MAX_NODES; i++) begin
			dvd[2+i] = (cfg.nodes > NCNT_W'(1)) ? OFF_W'(cfg.cap[i] >> 1) : OFF_W'(cfg.cap[i]);
		end
		if (state_q == F_CHECK) begin
			dvd[0] = quo[0];
			dvs[0] = LEN_W'(cfg.nodes);
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		smpm_div u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.start     (start[g]),
			.dividend  (dvd[g]),
			.divisor   (dvs[g]),
			.busy      (busy[g]),
			.quotient  (quo[g]),
			.remainder (rem[g])
		);
	end

	// usable capacity per node, the smallest over the nodes in use, the exposed range and the request status
	always_comb begin
		min_cap = '1;
		for (int i = 0; i < MAX_NODES; i++) begin
			usable[i] = CAP_W'(dvd[2+i] - OFF_W'(rem[2+i]));
			if (NCNT_W'(i) < cfg.nodes && usable[i] < min_cap) begin
				min_cap = usable[i];
			end
		end
		exposed = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			if (NCNT_W'(i) < cfg.nodes) begin
				exposed = exposed + OFF_W'(min_cap);
			end
		end
		span = quo[1] - quo[0];
		single = 1'b1;
		status = ST_OK;
		if (req_q.start_offset > exposed) begin
			status = ST_OFFSET;
		end else if (OFF_W'(req_q.request_length) > exposed - req_q.start_offset) begin
			status = ST_RANGE;
		end else if (req_q.request_length == '0) begin
			status = ST_OK;
		end else if (span >= OFF_W'(MAX_SEGMENTS)) begin
			status = ST_TOO_MANY;
		end else begin
			single = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE:  if (in_valid) state_d = F_DIV1;
			F_DIV1:  if (busy == '0) state_d = F_CHECK;
			F_CHECK: state_d = single ? F_PUSH : F_DIV2;
			F_DIV2:  if (!busy[0]) state_d = F_MUL;
			F_MUL:   if (mcnt_q == '0) state_d = F_PUSH;
			F_PUSH:  if (!full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		start    = '0;
		push     = 1'b0;
		case (state_q)
			F_IDLE: begin
				in_stall = 1'b0;
				start    = {LANES{in_valid}};
			end
			F_CHECK: start[0] = !single;
			F_PUSH:  push = !full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: if (in_valid) req_q <= in_data;
			F_CHECK: begin
				cmd_q.single    <= single;
				cmd_q.status    <= status;
				cmd_q.off       <= (status == ST_OK) ? req_q.start_offset : '0;
				cmd_q.len       <= req_q.request_length;
				cmd_q.in_stripe <= rem[0];
				cmd_q.p0        <= '0;
				cmd_q.base      <= '0;
				cmd_q.usable    <= usable;
			end
			F_DIV2: if (!busy[0]) begin
				cmd_q.p0 <= NODE_W'(rem[0]);
				row_q    <= CAP_W'(quo[0]);
				mcnt_q   <= MCNT_W'(LEN_W - 1);
			end
			// shift-add multiply of row by stripe, stripe MSB first
			F_MUL: begin
				cmd_q.base <= CAP_W'({cmd_q.base, 1'b0})
					+ (cfg.stripe[mcnt_q] ? row_q : '0);
				mcnt_q <= mcnt_q - MCNT_W'(1);
			end
			default: ;
		endcase
	end

	assign cmd = cmd_q;
endmodule

FILE: hdl/smpm_queue.sv
// Two-word command queue between front and back.
module smpm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  smpm_pkg::cmd_t  wdata,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output smpm_pkg::cmd_t  rdata
);
	import smpm_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];
endmodule

FILE: hdl/smpm_back.sv
// Back end: walks the stripes of one command and emits one word per segment.
module smpm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  smpm_pkg::cfg_t  cfg,
	input  logic            empty,
	input  smpm_pkg::cmd_t  cmd,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output smpm_pkg::seg_t  out_data
);
	import smpm_pkg::*;

	logic                            active_q, single_q;
	logic [STAT_W-1:0]               status_q;
	logic [OFF_W-1:0]                cur_q;
	logic [LEN_W-1:0]                rem_q, ins_q;
	logic [NODE_W-1:0]               p_q;
	logic [CAP_W-1:0]                base_q;
	logic [MAX_NODES-1:0][CAP_W-1:0] usable_q;
	logic                            ov_q;
	seg_t                            o_q, seg;
	logic                            slot;
	logic [LEN_W-1:0]                avail, len;
	logic [CAP_W-1:0]                local_off;
	logic [NODE_W-1:0]               m;
	logic                            wrap, last;

	assign slot  = !ov_q || !out_stall;
	assign pop   = !active_q && !empty;
	assign avail = cfg.stripe - ins_q;
	assign len   = (rem_q < avail) ? rem_q : avail;
	assign last  = single_q || rem_q == len;
	assign wrap  = NCNT_W'(p_q) + NCNT_W'(1) == cfg.nodes;
	assign m     = wrap ? '0 : NODE_W'(p_q + NODE_W'(1));
	assign local_off = base_q + CAP_W'(ins_q);

	always_comb begin
		seg = '0;
		seg.seg_offset   = cur_q;
		seg.status       = status_q;
		seg.last_segment = last;
		if (!single_q) begin
			seg.seg_length     = len;
			seg.primary_node   = 2'(p_q);
			seg.primary_offset = local_off;
			seg.primary_up     = cfg.active[p_q];
			if (cfg.nodes > NCNT_W'(1)) begin
				seg.mirror_present = 1'b1;
				seg.mirror_node    = 2'(m);
				seg.mirror_offset  = local_off + usable_q[m];
				seg.mirror_up      = cfg.active[m];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
			end else if (active_q && slot && last) begin
				active_q <= 1'b0;
			end
			if (active_q && slot) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			single_q <= cmd.single;
			status_q <= cmd.status;
			cur_q    <= cmd.off;
			rem_q    <= cmd.len;
			ins_q    <= cmd.in_stripe;
			p_q      <= cmd.p0;
			base_q   <= cmd.base;
			usable_q <= cmd.usable;
		end else if (active_q && slot) begin
			// advance to the next stripe
			cur_q  <= cur_q + OFF_W'(len);
			rem_q  <= rem_q - len;
			ins_q  <= '0;
			p_q    <= m;
			if (wrap) base_q <= base_q + CAP_W'(cfg.stripe);
		end
		if (active_q && slot) o_q <= seg;
	end

	assign out_valid = ov_q;
	assign out_data  = o_q;
endmodule

FILE: hdl/striped_mirror_placement_mapper.sv
// Top level: configuration registers, front end, command queue and back end.
// The divider lanes classify a request; when segments follow, a second division
// and the serial multiply find the first node and its base offset.
// The front takes a new request only once it has pushed the last command; segments
// then leave at one per cycle while out_stall is low.
// Reset: arst_n clears control state and loads the register reset values.
module striped_mirror_placement_mapper (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  smpm_pkg::req_t                 in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output smpm_pkg::seg_t                 out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [smpm_pkg::IDX_W-1:0]     cfg_index,
	input  logic [smpm_pkg::CAP_W-1:0]     cfg_data
);
	import smpm_pkg::*;

	logic [LEN_W-1:0]                stripe_q;
	logic [2:0]                      nodes_q;
	logic [MAX_NODES-1:0][CAP_W-1:0] cap_q;
	logic [3:0]                      active_q;
	cfg_t                            cfg;
	cmd_t                            wcmd, rcmd;
	logic                            push, full, pop, empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stripe_q <= LEN_W'(4096);
			nodes_q  <= 3'd1;
			cap_q    <= '0;
			active_q <= 4'hf;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_STRIPE: stripe_q <= cfg_data[LEN_W-1:0];
				REG_NODES:  nodes_q  <= cfg_data[2:0];
				REG_CAP0:   cap_q[0] <= cfg_data;
				REG_CAP1:   cap_q[1] <= cfg_data;
				REG_CAP2:   cap_q[2] <= cfg_data;
				REG_CAP3:   cap_q[3] <= cfg_data;
				REG_ACTIVE: active_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.stripe = (stripe_q == '0) ? LEN_W'(1) : stripe_q;
		if (nodes_q == '0) begin
			cfg.nodes = NCNT_W'(1);
		end else if (nodes_q > 3'(MAX_NODES)) begin
			cfg.nodes = NCNT_W'(MAX_NODES);
		end else begin
			cfg.nodes = NCNT_W'(nodes_q);
		end
		cfg.active = active_q;
		cfg.cap    = cap_q;
	end

	smpm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.push     (push),
		.full     (full),
		.cmd      (wcmd)
	);

	smpm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wcmd),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (rcmd)
	);

	smpm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.empty     (empty),
		.cmd       (rcmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);
endmodule

FILE: hdl/smpm_checker.sv
// Port-level checker for the mapper, bound to the top level.
module smpm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_stall,
	input smpm_pkg::seg_t out_data
);
	import smpm_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.last_segment
			&& out_data.seg_length == '0 && out_data.seg_offset == '0)
		else $error("error word not alone");

	a_no_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.mirror_present |-> out_data.mirror_offset == '0
			&& out_data.mirror_node == '0 && !out_data.mirror_up)
		else $error("mirror fields set without mirror");

	a_mirror_node: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.mirror_present |->
			out_data.mirror_node != out_data.primary_node)
		else $error("mirror on primary node");
endmodule

bind striped_mirror_placement_mapper smpm_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
